// File: src/dppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppt_pkg
// Shared types and constants for the demand paging page table.
// ----------------------------------------------------------------------------
package dppt_pkg;

	localparam int DEF_PAGE_BYTES  = 16;
	localparam int DEF_NUM_FRAMES  = 16;
	localparam int DEF_MAX_PAGES   = 64;

	localparam int VADDR_W = 10;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 7;
	localparam int CFG_A_W = 2;
	localparam int VPN_W   = 6;
	localparam int STAMP_W = 32;
	localparam int PIU_RST = 64;

	localparam logic [CFG_A_W-1:0] REG_TEXT_END = 2'd0;
	localparam logic [CFG_A_W-1:0] REG_DATA_END = 2'd1;
	localparam logic [CFG_A_W-1:0] REG_BSS_END  = 2'd2;
	localparam logic [CFG_A_W-1:0] REG_PAGES    = 2'd3;

	localparam logic [1:0] ST_HIT   = 2'd0;
	localparam logic [1:0] ST_FAULT = 2'd1;
	localparam logic [1:0] ST_INVAL = 2'd2;
	localparam logic [1:0] ST_HEAP  = 2'd3;

	localparam logic [1:0] FILL_NONE  = 2'd0;
	localparam logic [1:0] FILL_IMAGE = 2'd1;
	localparam logic [1:0] FILL_SWAP  = 2'd2;
	localparam logic [1:0] FILL_ZERO  = 2'd3;

	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic               op;
		logic [VADDR_W-1:0] vaddr;
		logic [BYTE_W-1:0]  store_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BYTE_W-1:0] paddr;
		logic              do_write;
		logic [BYTE_W-1:0] write_data;
		logic [1:0]        fill_source;
		logic [VPN_W-1:0]  fill_page;
		logic              evicted;
		logic [VPN_W-1:0]  evict_page;
		logic              writeback;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] text_end;
		logic [CFG_W-1:0] data_end;
		logic [CFG_W-1:0] bss_end;
		logic [CFG_W-1:0] pages;
	} cfg_t;

	// item as it waits between front and back
	typedef struct packed {
		cmd_t cmd;
		logic bad;
	} q_item_t;

endpackage

// File: src/dppt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dppt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/dppt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppt_front
// Holds the configuration registers, takes items and flags bad addresses.
// ----------------------------------------------------------------------------
module dppt_front import dppt_pkg::*; #(
	parameter int PAGE_BYTES = DEF_PAGE_BYTES,
	parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cmd_t               cmd,
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               q_full,
	output logic               push,
	output q_item_t            push_item,
	output cfg_t               cfg
);

	localparam int OFF_W = $clog2(PAGE_BYTES);

	cfg_t              cfg_q;
	logic [VADDR_W-1:0] page_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_end <= '0;
			cfg_q.data_end <= '0;
			cfg_q.bss_end  <= '0;
			cfg_q.pages    <= CFG_W'(PIU_RST);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TEXT_END: cfg_q.text_end <= cfg_wdata;
				REG_DATA_END: cfg_q.data_end <= cfg_wdata;
				REG_BSS_END:  cfg_q.bss_end  <= cfg_wdata;
				REG_PAGES:    cfg_q.pages    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign page_full     = VADDR_W'(32'(cmd.vaddr) >> OFF_W);
	assign push          = start && !q_full;
	assign push_item.cmd = cmd;
	assign push_item.bad = (32'(page_full) >= 32'(cfg_q.pages))
		|| (32'(page_full) >= 32'(MAX_PAGES));
	assign cfg           = cfg_q;

endmodule

// File: src/dppt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppt_queue
// Two-entry queue of items between the front and the back.
// ----------------------------------------------------------------------------
module dppt_queue import dppt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	input  logic    pop,
	output q_item_t head,
	output logic    empty,
	output logic    full
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	q_item_t            mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(Q_DEPTH));

endmodule

// File: src/dppt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppt_back
// Page table, free frame scan, victim search and result register.
// ----------------------------------------------------------------------------
module dppt_back import dppt_pkg::*; #(
	parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
	parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
	parameter int MAX_PAGES   = DEF_MAX_PAGES
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  q_item_t head,
	input  logic    empty,
	output logic    pop,
	output logic    rsp_valid,
	output rsp_t    rsp
);

	localparam int OFF_W = $clog2(PAGE_BYTES);
	localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int FRM_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_HIT, S_FREE, S_VSCAN, S_VLAST, S_VFRM, S_VGET, S_FILL
	} state_t;

	state_t              state_q;
	q_item_t             item_q;
	logic [1:0]          src_q;
	logic [FRM_W-1:0]    frame_q;
	logic [FRM_W-1:0]    f_q;
	logic [PG_W-1:0]     i_q;
	logic [PG_W-1:0]     rd_idx_s1;
	logic                rd_vld_s1;
	logic [STAMP_W-1:0]  best_q;
	logic                found_q;
	logic [PG_W-1:0]     victim_q;
	logic                ev_q;
	logic                wb_q;
	logic [STAMP_W-1:0]  cnt_q;
	logic [MAX_PAGES-1:0]   valid_q;
	logic [MAX_PAGES-1:0]   dirty_q;
	logic [MAX_PAGES-1:0]   swap_q;
	logic [NUM_FRAMES-1:0]  busy_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic [VADDR_W-1:0]  page_full;
	logic [PG_W-1:0]     pidx;
	logic [31:0]         off32;
	logic [1:0]          src;
	logic                heap_err;
	logic                lru_take;
	logic [FRM_W-1:0]    frm_rdata;
	logic [STAMP_W-1:0]  lu_rdata;
	logic                frm_we;
	logic                lu_we;
	logic [PG_W-1:0]     frm_raddr;

	function automatic rsp_t make_rsp(input logic [1:0] st, input logic [FRM_W-1:0] frm,
		input logic [31:0] off, input cmd_t c, input logic [1:0] fs,
		input logic [31:0] fpg, input logic ev, input logic [31:0] epg, input logic wb);
		rsp_t        r;
		logic [31:0] pa;
		pa = 32'(frm) * PAGE_BYTES + off;
		r.status      = st;
		r.paddr       = pa[BYTE_W-1:0];
		r.do_write    = c.op;
		r.write_data  = c.op ? c.store_value : '0;
		r.fill_source = fs;
		r.fill_page   = fpg[VPN_W-1:0];
		r.evicted     = ev;
		r.evict_page  = epg[VPN_W-1:0];
		r.writeback   = wb;
		return r;
	endfunction

	assign page_full = VADDR_W'(32'(item_q.cmd.vaddr) >> OFF_W);
	assign pidx      = page_full[PG_W-1:0];
	assign off32     = 32'(item_q.cmd.vaddr) & (PAGE_BYTES - 1);

	always_comb begin
		if (32'(pidx) < 32'(cfg.text_end)) begin
			src = FILL_IMAGE;
		end else if (swap_q[pidx]) begin
			src = FILL_SWAP;
		end else if (32'(pidx) < 32'(cfg.data_end)) begin
			src = FILL_IMAGE;
		end else begin
			src = FILL_ZERO;
		end
	end

	assign heap_err = (src == FILL_ZERO) && !item_q.cmd.op
		&& (32'(pidx) >= 32'(cfg.bss_end));
	// lru compare on the entry whose stamp has just been read
	assign lru_take = rd_vld_s1 && valid_q[rd_idx_s1] && (!found_q || lu_rdata < best_q);

	assign pop       = (state_q == S_IDLE) && !empty;
	assign frm_we    = (state_q == S_FILL);
	assign lu_we     = (state_q == S_FILL)
		|| (state_q == S_LOOK && !item_q.bad && valid_q[pidx]);
	assign frm_raddr = (state_q == S_LOOK) ? pidx : victim_q;

	dppt_ram #(.WIDTH(FRM_W), .DEPTH(MAX_PAGES)) u_frame_ram (
		.clk   (clk),
		.we    (frm_we),
		.waddr (pidx),
		.wdata (frame_q),
		.raddr (frm_raddr),
		.rdata (frm_rdata)
	);

	dppt_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_PAGES)) u_stamp_ram (
		.clk   (clk),
		.we    (lu_we),
		.waddr (pidx),
		.wdata (cnt_q),
		.raddr (i_q),
		.rdata (lu_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			dirty_q     <= '0;
			swap_q      <= '0;
			busy_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// every strobe is followed by an idle cycle, which ends it
					rsp_valid_q <= 1'b0;
					if (!empty) begin
						item_q  <= head;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (item_q.bad) begin
						rsp_q       <= {ST_INVAL, ($bits(rsp_t) - 2)'(0)};
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (valid_q[pidx]) begin
						if (item_q.cmd.op) begin
							dirty_q[pidx] <= 1'b1;
						end
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_HIT;
					end else if (heap_err) begin
						rsp_q        <= {ST_HEAP, ($bits(rsp_t) - 2)'(0)};
						rsp_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						src_q   <= src;
						f_q     <= '0;
						state_q <= S_FREE;
					end
				end
				S_HIT: begin
					rsp_q <= make_rsp(ST_HIT, frm_rdata, off32, item_q.cmd, FILL_NONE,
						32'd0, 1'b0, 32'd0, 1'b0);
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FREE: begin
					if (!busy_q[f_q]) begin
						frame_q <= f_q;
						ev_q    <= 1'b0;
						wb_q    <= 1'b0;
						state_q <= S_FILL;
					end else if (f_q == FRM_W'(NUM_FRAMES - 1)) begin
						i_q       <= '0;
						found_q   <= 1'b0;
						rd_vld_s1 <= 1'b0;
						state_q   <= S_VSCAN;
					end else begin
						f_q <= f_q + 1'b1;
					end
				end
				S_VSCAN: begin
					rd_vld_s1 <= 1'b1;
					rd_idx_s1 <= i_q;
					if (lru_take) begin
						found_q  <= 1'b1;
						best_q   <= lu_rdata;
					end
					// first clean resident page wins outright
					if (valid_q[i_q] && !dirty_q[i_q]) begin
						victim_q <= i_q;
						state_q  <= S_VFRM;
					end else begin
						if (lru_take) begin
							victim_q <= rd_idx_s1;
						end
						if (i_q == PG_W'(MAX_PAGES - 1)) begin
							state_q <= S_VLAST;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				S_VLAST: begin
					rd_vld_s1 <= 1'b0;
					if (lru_take) begin
						victim_q <= rd_idx_s1;
					end
					if (lru_take || found_q) begin
						state_q <= S_VFRM;
					end else begin
						frame_q <= '0;
						ev_q    <= 1'b0;
						wb_q    <= 1'b0;
						state_q <= S_FILL;
					end
				end
				S_VFRM: begin
					rd_vld_s1 <= 1'b0;
					state_q   <= S_VGET;
				end
				S_VGET: begin
					frame_q <= frm_rdata;
					ev_q    <= 1'b1;
					wb_q    <= dirty_q[victim_q];
					if (dirty_q[victim_q]) begin
						swap_q[victim_q] <= 1'b1;
					end
					valid_q[victim_q] <= 1'b0;
					dirty_q[victim_q] <= 1'b0;
					state_q           <= S_FILL;
				end
				S_FILL: begin
					busy_q[frame_q] <= 1'b1;
					valid_q[pidx]   <= 1'b1;
					dirty_q[pidx]   <= item_q.cmd.op;
					cnt_q           <= cnt_q + 1'b1;
					rsp_q <= make_rsp(ST_FAULT, frame_q, off32, item_q.cmd, src_q,
						32'(pidx), ev_q, ev_q ? 32'(victim_q) : 32'd0, wb_q);
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: src/demand_paging_page_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paging_page_table
// Virtual to physical translation, demand fill, first-clean-else-lru replacement.
//
//   channel   handshake          payload
//   command   start / busy       cmd (op, vaddr, store_value)
//   result    rsp_valid strobe   rsp (status ... writeback)
//   config    cfg_we             cfg_addr, cfg_wdata
//
// with the back idle, a bad address or heap read error is answered from the lookup
// state, a hit from the hit state after it, a fault with a free frame from the fill state after the free frame scan
// a fault with all frames busy scans the busy map, then the page table one entry
// a cycle, stopping at the first clean resident page, and then fills
// busy rises when the two-entry item queue is full; reset clears the valid, dirty,
// swap and busy frame maps; results are a one-cycle strobe and cannot be held off
// ----------------------------------------------------------------------------
module demand_paging_page_table import dppt_pkg::*; #(
	parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
	parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
	parameter int MAX_PAGES   = DEF_MAX_PAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cmd_t               cmd,
	output logic               rsp_valid,
	output rsp_t               rsp,
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	logic    push;
	q_item_t push_item;
	cfg_t    cfg;
	logic    pop;
	q_item_t head;
	logic    empty;
	logic    full;

	dppt_front #(.PAGE_BYTES(PAGE_BYTES), .MAX_PAGES(MAX_PAGES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.q_full    (full),
		.push      (push),
		.push_item (push_item),
		.cfg       (cfg)
	);

	dppt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	dppt_back #(
		.PAGE_BYTES  (PAGE_BYTES),
		.NUM_FRAMES  (NUM_FRAMES),
		.MAX_PAGES   (MAX_PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	assign busy = full;

endmodule

// File: src/dppt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppt_checker
// Port-level checks on the result channel of the page table.
// ----------------------------------------------------------------------------
module dppt_checker import dppt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input rsp_t rsp
);

	// every item passes an idle and a lookup cycle, so strobes never touch
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |=> !rsp_valid)
		else $error("result strobes back to back");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_INVAL || rsp.status == ST_HEAP)
		|-> rsp.paddr == '0 && !rsp.do_write && rsp.fill_source == FILL_NONE
			&& !rsp.evicted && !rsp.writeback)
		else $error("rejected item carries payload");

	a_hit_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_HIT
		|-> rsp.fill_source == FILL_NONE && !rsp.evicted && rsp.fill_page == '0)
		else $error("hit reports a fill or eviction");

	a_wb_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.evicted |-> !rsp.writeback && rsp.evict_page == '0)
		else $error("writeback without eviction");

endmodule

bind demand_paging_page_table dppt_checker u_dppt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);
